[design/skf_pkg.sv]
// Shared widths, register indices and reset values for the scalar Kalman filter.
// Used by skf_div, skf_mul and scalar_kalman_filter_core; depends on nothing.
`default_nettype none

package skf_pkg;

   // Field and state widths
   localparam int SKF_DATA_W    = 32;                  // samples, registers, covariance
   localparam int SKF_FRAC_W    = 16;                  // fraction bits of Q16 values
   localparam int SKF_EST_W     = SKF_DATA_W + SKF_FRAC_W;   // estimate, Q32.16
   localparam int SKF_DIFF_W    = SKF_EST_W + 1;       // innovation before magnitude
   localparam int SKF_GAIN_W    = SKF_FRAC_W + 1;      // gain 0..1.0 inclusive
   localparam int SKF_CSR_IDX_W = 2;

   localparam logic [SKF_GAIN_W-1:0] SKF_GAIN_ONE = SKF_GAIN_W'(1) << SKF_FRAC_W;

   // Register indices
   localparam logic [SKF_CSR_IDX_W-1:0] SKF_REG_PROCESS_NOISE     = 2'd0;
   localparam logic [SKF_CSR_IDX_W-1:0] SKF_REG_MEASUREMENT_NOISE = 2'd1;
   localparam logic [SKF_CSR_IDX_W-1:0] SKF_REG_INITIAL_ERROR_COV = 2'd2;
   localparam logic [SKF_CSR_IDX_W-1:0] SKF_REG_INITIAL_ESTIMATE  = 2'd3;

   // Register reset values
   localparam logic [SKF_DATA_W-1:0] SKF_RST_PROCESS_NOISE     = 32'd262144; // 4.0
   localparam logic [SKF_DATA_W-1:0] SKF_RST_MEASUREMENT_NOISE = 32'd40960;  // 0.625
   localparam logic [SKF_DATA_W-1:0] SKF_RST_INITIAL_ERROR_COV = 32'd27525;  // 0.42
   localparam logic [SKF_DATA_W-1:0] SKF_RST_INITIAL_ESTIMATE  = 32'd0;

endpackage

`default_nettype wire

[design/skf_div.sv]
// Serial restoring divider: quot = floor(numer * 2^FRAC / denom), numer <= denom.
// One quotient bit per cycle after the load cycle. Uses skf_pkg for defaults.
`default_nettype none

module skf_div #(
   parameter int NUM_W = skf_pkg::SKF_DATA_W,
   parameter int FRAC  = skf_pkg::SKF_FRAC_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [NUM_W:0]   denom,
   output logic                  done,
   output logic [FRAC:0]         quot
);

   localparam int DEN_W = NUM_W + 1;
   localparam int CNT_W = (FRAC > 1) ? $clog2(FRAC) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             dnz_ff, dnz_in;
   logic [FRAC:0]    quot_ff, quot_in;

   logic [DEN_W-1:0] numer_ext;
   logic             top_bit;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   den_wide;
   logic [DEN_W:0]   trial_diff;
   logic             trial_ge;

   always_comb begin
      numer_ext  = {1'b0, numer};
      // integer bit of the gain: only set when numerator reaches the divisor
      top_bit    = (denom != '0) && (numer_ext >= denom);
      trial      = {rem_ff, 1'b0};
      den_wide   = {1'b0, den_ff};
      trial_diff = trial - den_wide;
      trial_ge   = dnz_ff && (trial >= den_wide);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dnz_in  = dnz_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = denom;
         dnz_in  = (denom != '0);
         rem_in  = top_bit ? (numer_ext - denom) : numer_ext;
         quot_in = {{FRAC{1'b0}}, top_bit};
      end else if (busy_ff) begin
         // one fraction bit per cycle
         rem_in  = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {quot_ff[FRAC-1:0], trial_ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(FRAC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      dnz_ff  <= dnz_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

[design/skf_mul.sv]
// Serial shift-add multiplier: product = (mcand * mplier) >> SHIFT, exact floor.
// One multiplier bit per cycle, LSB first. Uses skf_pkg for defaults.
`default_nettype none

module skf_mul #(
   parameter int A_W   = skf_pkg::SKF_DATA_W,
   parameter int B_W   = skf_pkg::SKF_GAIN_W,
   parameter int SHIFT = skf_pkg::SKF_FRAC_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [A_W-1:0]         mcand,
   input  wire logic [B_W-1:0]         mplier,
   output logic                        done,
   output logic [A_W+B_W-SHIFT-1:0]    product
);

   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [A_W-1:0]   hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;

   logic [A_W:0]       psum;
   logic [A_W+B_W-1:0] full;

   always_comb begin
      psum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mcand;
         b_in    = mplier;
         hi_in   = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         // add partial product, shift right; dropped bit goes to the low word
         hi_in  = psum[A_W:1];
         lo_in  = {psum[0], lo_ff[B_W-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign full    = {hi_ff, lo_ff};
   assign done    = done_ff;
   assign product = full[A_W+B_W-1:SHIFT];

endmodule

`default_nettype wire

[design/scalar_kalman_filter_core.sv]
// Scalar Kalman filter core: one filtered estimate per sample transaction.
// rsp_valid rises after the request has gone through PREP, DIVGO, DIV, MULGO, MUL
// and OUT; req_stall holds off a new request until the core is back in idle, and the
// pace is set by the 16-step serial gain divider and the 17-step serial multipliers.
// Synchronous reset loads the register defaults and reloads estimate and covariance;
// any register write reloads them as well. Depends on skf_pkg, skf_div and skf_mul.
`default_nettype none

module scalar_kalman_filter_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [skf_pkg::SKF_DATA_W-1:0] req_sample,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [skf_pkg::SKF_DATA_W-1:0]      rsp_filtered,
   // register write port
   input  wire logic                                  csr_write,
   input  wire logic [skf_pkg::SKF_CSR_IDX_W-1:0]     csr_index,
   input  wire logic [skf_pkg::SKF_DATA_W-1:0]        csr_wdata
);

   localparam int DW = skf_pkg::SKF_DATA_W;
   localparam int FW = skf_pkg::SKF_FRAC_W;
   localparam int EW = skf_pkg::SKF_EST_W;
   localparam int XW = skf_pkg::SKF_DIFF_W;
   localparam int GW = skf_pkg::SKF_GAIN_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_DIVGO = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_MULGO = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [DW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in;
   logic [DW-1:0] p0_ff, p0_in;
   logic [DW-1:0] x0_ff, x0_in;

   // filter state
   logic signed [EW-1:0] est_ff, est_in;
   logic [DW-1:0]        cov_ff, cov_in;

   // per-transaction working registers
   logic [DW-1:0]   p1_ff, p1_in;
   logic [XW-1:0]   diff_ff, diff_in;
   logic [DW:0]     denom_ff, denom_in;
   logic [EW-1:0]   mag_ff, mag_in;
   logic            neg_ff, neg_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_filtered_ff, rsp_filtered_in;

   // datapath nets
   logic [DW:0]        p_sum;
   logic [DW-1:0]      p1_sat;
   logic [XW-1:0]      z_ext;
   logic [XW-1:0]      est_ext;
   logic [XW-1:0]      diff_neg;
   logic [DW-1:0]      est_int;
   logic               round_up;
   logic               out_free;
   logic               reload;

   logic               div_start, div_done;
   logic [GW-1:0]      gain;
   logic [GW-1:0]      gain_inv;
   logic               mul_start, delta_done, covm_done;
   logic [EW+GW-FW-1:0] delta_full;
   logic [DW+GW-FW-1:0] cov_full;
   logic [EW-1:0]      delta;

   assign div_start = (state_ff == ST_DIVGO);
   assign mul_start = (state_ff == ST_MULGO);
   assign gain_inv  = skf_pkg::SKF_GAIN_ONE - gain;
   assign delta     = delta_full[EW-1:0];

   // gain k = p1 * 2^16 / (p1 + r)
   skf_div #(
      .NUM_W (DW),
      .FRAC  (FW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (p1_ff),
      .denom  (denom_ff),
      .done   (div_done),
      .quot   (gain)
   );

   // correction k * |d| / 2^16
   skf_mul #(
      .A_W   (EW),
      .B_W   (GW),
      .SHIFT (FW)
   ) u_mul_delta (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mag_ff),
      .mplier  (gain),
      .done    (delta_done),
      .product (delta_full)
   );

   // covariance (1 - k) * p1 / 2^16
   skf_mul #(
      .A_W   (DW),
      .B_W   (GW),
      .SHIFT (FW)
   ) u_mul_cov (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (p1_ff),
      .mplier  (gain_inv),
      .done    (covm_done),
      .product (cov_full)
   );

   always_comb begin
      // predicted covariance, saturating
      p_sum   = {1'b0, cov_ff} + {1'b0, q_ff};
      p1_sat  = p_sum[DW] ? '1 : p_sum[DW-1:0];
      // innovation z * 2^16 - x
      z_ext   = {req_sample[DW-1], req_sample, {FW{1'b0}}};
      est_ext = {est_ff[EW-1], est_ff};
      diff_neg = XW'(0) - diff_ff;
      // truncate toward zero
      est_int  = est_ff[EW-1:FW];
      round_up = est_ff[EW-1] && (est_ff[FW-1:0] != '0);
      out_free = !rsp_valid_ff || !rsp_stall;

      state_in        = state_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      p0_in           = p0_ff;
      x0_in           = x0_ff;
      est_in          = est_ff;
      cov_in          = cov_ff;
      p1_in           = p1_ff;
      diff_in         = diff_ff;
      denom_in        = denom_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_filtered_in = rsp_filtered_ff;
      reload          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               p1_in    = p1_sat;
               diff_in  = z_ext - est_ext;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            denom_in = {1'b0, p1_ff} + {1'b0, r_ff};
            neg_in   = diff_ff[XW-1];
            mag_in   = diff_ff[XW-1] ? diff_neg[EW-1:0] : diff_ff[EW-1:0];
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MULGO;
            end
         end
         ST_MULGO: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // both multipliers run in lockstep
            if (delta_done && covm_done) begin
               est_in   = neg_ff ? (est_ff - delta) : (est_ff + delta);
               cov_in   = cov_full[DW-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = est_int + DW'(round_up);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes store the value and reload the filter state
      if (csr_write) begin
         case (csr_index)
            skf_pkg::SKF_REG_PROCESS_NOISE: begin
               q_in   = csr_wdata;
               reload = 1'b1;
            end
            skf_pkg::SKF_REG_MEASUREMENT_NOISE: begin
               r_in   = csr_wdata;
               reload = 1'b1;
            end
            skf_pkg::SKF_REG_INITIAL_ERROR_COV: begin
               p0_in  = csr_wdata;
               reload = 1'b1;
            end
            skf_pkg::SKF_REG_INITIAL_ESTIMATE: begin
               x0_in  = csr_wdata;
               reload = 1'b1;
            end
            default: begin
               reload = 1'b0;
            end
         endcase
      end
      if (reload) begin
         est_in = {x0_in, {FW{1'b0}}};
         cov_in = p0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= skf_pkg::SKF_RST_PROCESS_NOISE;
         r_ff         <= skf_pkg::SKF_RST_MEASUREMENT_NOISE;
         p0_ff        <= skf_pkg::SKF_RST_INITIAL_ERROR_COV;
         x0_ff        <= skf_pkg::SKF_RST_INITIAL_ESTIMATE;
         est_ff       <= {skf_pkg::SKF_RST_INITIAL_ESTIMATE, {FW{1'b0}}};
         cov_ff       <= skf_pkg::SKF_RST_INITIAL_ERROR_COV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         p0_ff        <= p0_in;
         x0_ff        <= x0_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1_ff           <= p1_in;
      diff_ff         <= diff_in;
      denom_ff        <= denom_in;
      mag_ff          <= mag_in;
      neg_ff          <= neg_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // gain divider finishes only while the sequencer waits for it
   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("gain divider finished outside its wait state");

   // the two multipliers stay in lockstep
   a_mul_lockstep : assert property (@(posedge clock) disable iff (reset)
      delta_done == covm_done)
      else $error("correction and covariance multipliers out of step");

   // updated covariance never exceeds the predicted covariance
   a_cov_shrinks : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MUL) && delta_done && !csr_write) |=> (cov_ff <= $past(p1_ff)))
      else $error("covariance grew during the update");

   // a finished result is only loaded once the output register is free
   a_out_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("result left the output state while the response was stalled");

endmodule

`default_nettype wire
